FILE: hw/rtl/lsr_pkg.sv
// Shared types for the LIFO stack with reverse: op codes, status codes, states, control bundles
`timescale 1ns / 1ps

package lsr_pkg;

  // operation codes carried in the func field
  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REVERSE = 2'd2,
    OP_QUERY   = 2'd3
  } lsr_op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } lsr_status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_DONE,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI
  } lsr_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        push_wr;       // write data_in at top, count up
    logic        pop_rd;        // read top-1, count down
    logic        rev_init;      // lo = 0, hi = count-1
    logic        rd_lo;         // read word at lo
    logic        rd_hi;         // read word at hi
    logic        cap_tmp;       // hold read word (entry at lo)
    logic        wr_lo;         // write read word (entry at hi) to lo
    logic        wr_hi;         // write held word to hi, step lo and hi
    logic        load_out;      // load result register
    logic        out_from_ram;  // result data comes from the read port
    lsr_status_t stat;          // status for the result
  } lsr_cmd_t;

  // flags from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic two_plus;  // at least two words stored
    logic rev_more;  // another swap remains after the current one
  } lsr_flags_t;

endpackage

FILE: hw/rtl/lifo_stack_with_reverse_core.sv
// Top level of the LIFO word stack with push, pop, in-place reverse and status query
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_func, in_data_in
//   out_     output     out_valid / out_stall out_data_out, out_status, out_fill_count,
//                                             out_is_empty
//
// Push, query and failed pop load the result register on acceptance; a pop passes through
// S_POP_DONE for the registered read of the word RAM. Reverse makes floor(n / 2) swaps for
// n stored words, each making two reads and two writes through the single RAM port pair.
// Reset clears the fill count; stored words stay undefined and are never read unwritten.
// A stalled result holds in the output register; in_stall rises while a pop or reverse
// is in progress and while a held result is not taken.
`timescale 1ns / 1ps

module lifo_stack_with_reverse_core
  import lsr_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [DATA_WIDTH-1:0]      in_data_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DATA_WIDTH-1:0]      out_data_out,
  output logic [1:0]                 out_status,
  output logic [$clog2(DEPTH+1)-1:0] out_fill_count,
  output logic                       out_is_empty
);

  localparam int CW = $clog2(DEPTH + 1);

  lsr_cmd_t      cmd;
  lsr_flags_t    flags;
  logic [CW-1:0] dp_count;

  // controller
  lsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  // datapath
  lsr_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data_in     (in_data_in),
    .cmd            (cmd),
    .flags          (flags),
    .count          (dp_count),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .out_is_empty   (out_is_empty)
  );

  // empty flag agrees with the fill count of the same beat
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_fill_count == '0)))
    else $error("empty flag disagrees with fill count");

  // failed operations return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_data_out == '0))
    else $error("failed operation returned nonzero data");

  // a push to a stack that is not full grows it by one word
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == OP_PUSH && dp_count != CW'(DEPTH))
      |=> (dp_count == $past(dp_count) + CW'(1)))
    else $error("push did not advance the fill count");

endmodule

FILE: hw/rtl/lsr_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module lsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/lsr_ctrl.sv
// Controller state machine for the LIFO stack: handshakes and command sequencing
`timescale 1ns / 1ps

module lsr_ctrl
  import lsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  lsr_flags_t flags,
  output lsr_cmd_t   cmd
);

  lsr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  lsr_op_t    op;

  assign op       = lsr_op_t'(in_func);
  // take a new beat only when idle and the result register is free or draining
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_POP && !flags.empty) begin
            state_nxt = S_POP_DONE;
          end else if (op == OP_REVERSE && flags.two_plus) begin
            state_nxt = S_REV_RD_LO;
          end
        end
      end
      S_POP_DONE:  state_nxt = S_IDLE;
      S_REV_RD_LO: state_nxt = S_REV_RD_HI;
      S_REV_RD_HI: state_nxt = S_REV_WR_LO;
      S_REV_WR_LO: state_nxt = S_REV_WR_HI;
      S_REV_WR_HI: state_nxt = flags.rev_more ? S_REV_RD_LO : S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.stat = STAT_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_PUSH: begin
              cmd.load_out = 1'b1;
              if (flags.full) begin
                cmd.stat = STAT_OVERFLOW;
              end else begin
                cmd.push_wr = 1'b1;
              end
            end
            OP_POP: begin
              if (flags.empty) begin
                cmd.load_out = 1'b1;
                cmd.stat     = STAT_EMPTY;
              end else begin
                cmd.pop_rd = 1'b1;
              end
            end
            OP_REVERSE: begin
              cmd.load_out = 1'b1;
              cmd.rev_init = flags.two_plus;
            end
            OP_QUERY: begin
              cmd.load_out = 1'b1;
            end
            default: cmd.load_out = 1'b1;
          endcase
        end
      end
      S_POP_DONE: begin
        cmd.load_out     = 1'b1;
        cmd.out_from_ram = 1'b1;
      end
      S_REV_RD_LO: cmd.rd_lo   = 1'b1;
      S_REV_RD_HI: begin
        cmd.rd_hi   = 1'b1;
        cmd.cap_tmp = 1'b1;
      end
      S_REV_WR_LO: cmd.wr_lo = 1'b1;
      S_REV_WR_HI: cmd.wr_hi = 1'b1;
      default: cmd.stat = STAT_OK;
    endcase
  end

  // result valid: set on load, cleared when the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/lsr_dpath.sv
// Datapath for the LIFO stack: word RAM, fill count, swap pointers and result register
`timescale 1ns / 1ps

module lsr_dpath
  import lsr_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [DATA_WIDTH-1:0]        in_data_in,
  input  lsr_cmd_t                     cmd,
  output lsr_flags_t                   flags,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic [DATA_WIDTH-1:0]        out_data_out,
  output logic [1:0]                   out_status,
  output logic [$clog2(DEPTH+1)-1:0]   out_fill_count,
  output logic                         out_is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         count_dec;
  logic [AW-1:0]         lo_r, hi_r;
  logic [DATA_WIDTH-1:0] tmp_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  lsr_status_t           out_status_r;
  logic [CW-1:0]         out_fill_r;
  logic                  out_empty_r;

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [DATA_WIDTH-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  assign count_dec = count_r - CW'(1);

  // flags for the controller
  assign flags.full     = (count_r == CW'(DEPTH));
  assign flags.empty    = (count_r == '0);
  assign flags.two_plus = (count_r > CW'(1));
  assign flags.rev_more = (({1'b0, lo_r} + (AW+1)'(2)) < {1'b0, hi_r});
  assign count          = count_r;

  // fill count update
  always_comb begin
    count_nxt = count_r;
    if (cmd.push_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_rd) begin
      count_nxt = count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // swap pointers and held word
  always_ff @(posedge clk) begin
    if (cmd.rev_init) begin
      lo_r <= '0;
      hi_r <= count_dec[AW-1:0];
    end else if (cmd.wr_hi) begin
      lo_r <= lo_r + AW'(1);
      hi_r <= hi_r - AW'(1);
    end
    if (cmd.cap_tmp) begin
      tmp_r <= ram_rd_data;
    end
  end

  // ram write mux
  always_comb begin
    ram_wr_en   = cmd.push_wr || cmd.wr_lo || cmd.wr_hi;
    ram_wr_addr = count_r[AW-1:0];
    ram_wr_data = in_data_in;
    priority if (cmd.wr_lo) begin
      ram_wr_addr = lo_r;
      ram_wr_data = ram_rd_data;
    end else if (cmd.wr_hi) begin
      ram_wr_addr = hi_r;
      ram_wr_data = tmp_r;
    end else begin
      ram_wr_addr = count_r[AW-1:0];
      ram_wr_data = in_data_in;
    end
  end

  // ram read mux
  always_comb begin
    ram_rd_en = cmd.pop_rd || cmd.rd_lo || cmd.rd_hi;
    priority if (cmd.rd_lo) begin
      ram_rd_addr = lo_r;
    end else if (cmd.rd_hi) begin
      ram_rd_addr = hi_r;
    end else begin
      ram_rd_addr = count_dec[AW-1:0];
    end
  end

  lsr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r   <= cmd.out_from_ram ? ram_rd_data : '0;
      out_status_r <= cmd.stat;
      out_fill_r   <= count_nxt;
      out_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;
  assign out_is_empty   = out_empty_r;

endmodule
